// ===== sv/pzbd_pkg.sv =====
// Shared types, constants and helper functions for the POSTNET zip barcode decoder.
`timescale 1ns / 1ps
`default_nettype none

package pzbd_pkg;

   // Field widths
   localparam int CHAR_W      = 8;
   localparam int ZIP_W       = 18;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int POS_W       = 6;
   localparam int GSUM_W      = 4;
   localparam int TOTAL_W     = 7;
   localparam int IDX_W       = 3;

   // Barcode framing
   localparam logic [POS_W-1:0] LAST_POS   = 6'd31;  // position of char 32
   localparam logic [POS_W-1:0] POS_MAX    = 6'd63;
   localparam logic [POS_W-1:0] DATA_FIRST = 6'd1;
   localparam logic [POS_W-1:0] DATA_LAST  = 6'd30;
   localparam logic [IDX_W-1:0] GROUP_LAST_BAR = 3'd4;
   localparam logic [IDX_W-1:0] ZIP_DIGITS     = 3'd5;
   localparam logic [GSUM_W-1:0] ZERO_GROUP    = 4'd11;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_BAR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BAR = 1'd1;
   localparam logic [CHAR_W-1:0] FULL_BAR_RESET = 8'd124;
   localparam logic [CHAR_W-1:0] HALF_BAR_RESET = 8'd58;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd3;

   // Default queue depths
   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Classified character handed from front to back
   typedef struct packed {
      logic full_bar;
      logic bad_char;
      logic last;
   } token_type;

   // One decoded barcode
   typedef struct packed {
      logic [ZIP_W-1:0]    zip_code;
      logic [STATUS_W-1:0] status;
   } result_type;

   // Weight of a full bar at each place of a five-bar group
   function automatic logic [GSUM_W-1:0] bar_weight(input logic [IDX_W-1:0] idx);
      logic [GSUM_W-1:0] w;
      begin
         case (idx)
            3'd0:    w = 4'd7;
            3'd1:    w = 4'd4;
            3'd2:    w = 4'd2;
            3'd3:    w = 4'd1;
            default: w = 4'd0;
         endcase
         return w;
      end
   endfunction

   // Remainder by ten of a 7-bit value, by conditional subtraction
   function automatic logic [3:0] mod10(input logic [TOTAL_W-1:0] value);
      logic [TOTAL_W-1:0] r;
      begin
         r = value;
         if (r >= 7'd80) r = r - 7'd80;
         if (r >= 7'd40) r = r - 7'd40;
         if (r >= 7'd20) r = r - 7'd20;
         if (r >= 7'd10) r = r - 7'd10;
         return r[3:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/postnet_zip_barcode_decoder_unit.sv =====
// Top level of the POSTNET zip barcode decoder: front end, token queue, back end, result queue.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a POSTNET barcode fed one character per transaction, with
// req_end_of_code set on the final character; that transaction yields one
// result (zip code and status). The block takes one character per clock
// cycle as long as results are drained. The front end classifies each
// character against the full-bar and half-bar codes and writes it into a
// small token queue; the back end retires one token per cycle through its
// position, group and checksum registers, which set the rate; only a last
// token waits, for room in the result queue. A result is registered into
// the result queue when its last token retires, so the input keeps
// flowing while a result is not yet popped. The bar code registers take a
// write every cycle and should only be written while no barcode is in flight.
module postnet_zip_barcode_decoder_unit #(
   parameter int REQ_QUEUE_DEPTH = pzbd_pkg::REQ_QUEUE_DEPTH,
   parameter int RSP_QUEUE_DEPTH = pzbd_pkg::RSP_QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // character transactions
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [pzbd_pkg::CHAR_W-1:0]      req_char_code,
   input  wire logic                             req_end_of_code,
   // result transactions
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [pzbd_pkg::ZIP_W-1:0]            rsp_zip_code,
   output logic [pzbd_pkg::STATUS_W-1:0]         rsp_status,
   // register writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pzbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pzbd_pkg::CHAR_W-1:0]      csr_wdata
);

   localparam int TOK_W = $bits(pzbd_pkg::token_type);
   localparam int RES_W = $bits(pzbd_pkg::result_type);

   pzbd_pkg::token_type  front_tok;
   pzbd_pkg::token_type  tok;
   pzbd_pkg::result_type res;
   pzbd_pkg::result_type rsp;
   logic [TOK_W-1:0]     tok_rdata;
   logic [RES_W-1:0]     rsp_rdata;
   logic                 tok_empty;
   logic                 tok_pop;
   logic                 res_full;
   logic                 res_push;

   assign csr_ready = 1'b1;

   pzbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .char_code   (req_char_code),
      .end_of_code (req_end_of_code),
      .token       (front_tok)
   );

   // Token queue between front and back
   pzbd_fifo #(
      .WIDTH (TOK_W),
      .DEPTH (REQ_QUEUE_DEPTH)
   ) u_tok_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_tok),
      .full  (full),
      .pop   (tok_pop),
      .rdata (tok_rdata),
      .empty (tok_empty)
   );

   assign tok = pzbd_pkg::token_type'(tok_rdata);

   pzbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (tok_empty),
      .tok       (tok),
      .tok_pop   (tok_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   // Result queue toward the consumer
   pzbd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res),
      .full  (res_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp          = pzbd_pkg::result_type'(rsp_rdata);
   assign rsp_zip_code = rsp.zip_code;
   assign rsp_status   = rsp.status;

`ifndef SYNTH
   // A failed barcode never reports a zip value
   a_zip_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != pzbd_pkg::STATUS_OK) |-> (rsp_zip_code == '0))
      else $error("nonzero zip code with failing status");

   // Input back-pressure only when the token queue holds work
   a_full_has_tokens: assert property (@(posedge clock) disable iff (reset)
      full |-> !tok_empty)
      else $error("input full while token queue is empty");

   // A result is produced only by retiring a last-character token
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (tok_pop && tok.last && !res_full))
      else $error("result written without a last-character token");

   // A pending last token is held back only by a full result queue
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      (!tok_empty && !tok_pop) |-> (tok.last && res_full))
      else $error("back end stalled without cause");
`endif

endmodule

`default_nettype wire

// ===== sv/pzbd_fifo.sv =====
// Small register-based FIFO used for the token and result queues.
`timescale 1ns / 1ps
`default_nettype none

module pzbd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign rdata   = data_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pzbd_front.sv =====
// Front end: bar code registers and per-character classification.
`timescale 1ns / 1ps
`default_nettype none

module pzbd_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [pzbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pzbd_pkg::CHAR_W-1:0]      csr_wdata,
   input  wire logic [pzbd_pkg::CHAR_W-1:0]      char_code,
   input  wire logic                             end_of_code,
   output pzbd_pkg::token_type                   token
);

   logic [pzbd_pkg::CHAR_W-1:0] full_bar_ff;
   logic [pzbd_pkg::CHAR_W-1:0] half_bar_ff;
   logic                        is_full;
   logic                        is_half;

   // Configuration writes; always ready
   always_ff @(posedge clock) begin
      if (reset) begin
         full_bar_ff <= pzbd_pkg::FULL_BAR_RESET;
         half_bar_ff <= pzbd_pkg::HALF_BAR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pzbd_pkg::CSR_FULL_BAR: full_bar_ff <= csr_wdata;
            pzbd_pkg::CSR_HALF_BAR: half_bar_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify: matching both codes counts as a full bar
   assign is_full = (char_code == full_bar_ff);
   assign is_half = (char_code == half_bar_ff);

   always_comb begin
      token.full_bar = is_full;
      token.bad_char = ~(is_full | is_half);
      token.last     = end_of_code;
   end

endmodule

`default_nettype wire

// ===== sv/pzbd_back.sv =====
// Back end: group decoding, zip and checksum accumulation, status on the last character.
`timescale 1ns / 1ps
`default_nettype none

module pzbd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_empty,
   input  pzbd_pkg::token_type       tok,
   output logic                      tok_pop,
   input  wire logic                 res_full,
   output logic                      res_push,
   output pzbd_pkg::result_type      res
);

   logic [pzbd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         bad_ff, bad_in;
   logic [pzbd_pkg::GSUM_W-1:0]  gsum_ff, gsum_in;
   logic [pzbd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [pzbd_pkg::ZIP_W-1:0]   zip_ff, zip_in;
   logic [pzbd_pkg::IDX_W-1:0]   bar_idx_ff, bar_idx_in;
   logic [pzbd_pkg::IDX_W-1:0]   group_idx_ff, group_idx_in;

   logic                         in_data;
   logic                         group_end;
   logic [pzbd_pkg::GSUM_W-1:0]  gsum_next;
   logic [pzbd_pkg::GSUM_W-1:0]  digit;
   logic [pzbd_pkg::TOTAL_W-1:0] total_next;
   logic [pzbd_pkg::ZIP_W-1:0]   zip_next;
   logic                         bad_next;

   // Take a token unless it would finish a barcode with no room for the result
   assign tok_pop  = ~tok_empty & (~tok.last | ~res_full);
   assign res_push = tok_pop & tok.last;

   // Decode of the current character
   always_comb begin
      in_data   = (pos_ff >= pzbd_pkg::DATA_FIRST) && (pos_ff <= pzbd_pkg::DATA_LAST);
      group_end = in_data && (bar_idx_ff == pzbd_pkg::GROUP_LAST_BAR);
      gsum_next = gsum_ff;
      if (in_data && tok.full_bar) begin
         gsum_next = gsum_ff + pzbd_pkg::bar_weight(bar_idx_ff);
      end
      digit      = (gsum_next == pzbd_pkg::ZERO_GROUP) ? '0 : gsum_next;
      total_next = total_ff;
      zip_next   = zip_ff;
      if (group_end) begin
         total_next = total_ff + pzbd_pkg::TOTAL_W'(digit);
         if (group_idx_ff < pzbd_pkg::ZIP_DIGITS) begin
            // zip * 10 + digit as shifts and adds
            zip_next = (zip_ff << 3) + (zip_ff << 1) + pzbd_pkg::ZIP_W'(digit);
         end
      end
      bad_next = bad_ff | tok.bad_char;
   end

   // Result on the last character, in priority order
   always_comb begin
      if (pos_ff != pzbd_pkg::LAST_POS) begin
         res.status = pzbd_pkg::STATUS_LENGTH;
      end else if (bad_next) begin
         res.status = pzbd_pkg::STATUS_BAD_CHAR;
      end else if (pzbd_pkg::mod10(total_next) != 4'd0) begin
         res.status = pzbd_pkg::STATUS_CHECKSUM;
      end else begin
         res.status = pzbd_pkg::STATUS_OK;
      end
      res.zip_code = (res.status == pzbd_pkg::STATUS_OK) ? zip_next : '0;
   end

   // Next state
   always_comb begin
      pos_in       = pos_ff;
      bad_in       = bad_ff;
      gsum_in      = gsum_ff;
      total_in     = total_ff;
      zip_in       = zip_ff;
      bar_idx_in   = bar_idx_ff;
      group_idx_in = group_idx_ff;
      if (tok_pop) begin
         if (tok.last) begin
            pos_in       = '0;
            bad_in       = 1'b0;
            gsum_in      = '0;
            total_in     = '0;
            zip_in       = '0;
            bar_idx_in   = '0;
            group_idx_in = '0;
         end else begin
            pos_in   = (pos_ff == pzbd_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
            bad_in   = bad_next;
            total_in = total_next;
            zip_in   = zip_next;
            if (group_end) begin
               gsum_in      = '0;
               bar_idx_in   = '0;
               group_idx_in = group_idx_ff + 1'b1;
            end else if (in_data) begin
               gsum_in    = gsum_next;
               bar_idx_in = bar_idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         bad_ff       <= 1'b0;
         gsum_ff      <= '0;
         total_ff     <= '0;
         zip_ff       <= '0;
         bar_idx_ff   <= '0;
         group_idx_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         bad_ff       <= bad_in;
         gsum_ff      <= gsum_in;
         total_ff     <= total_in;
         zip_ff       <= zip_in;
         bar_idx_ff   <= bar_idx_in;
         group_idx_ff <= group_idx_in;
      end
   end

endmodule

`default_nettype wire
